// File: design/bsr_pkg.sv
// Shared types and codes for the bounded stack with reverse.
package bsr_pkg;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_REVERSE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [31:0] EMPTY_POP_WORD = -32'sd999;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } t_res;

endpackage

// File: design/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bounded_stack_with_reverse_unit.sv
// Top level: bounded LIFO stack of signed words with push, pop and in-place reverse.
//
// A request word is taken when start is high and busy is low; exactly one result
// word follows, shown on o_res for a single cycle with o_done high. The receiver
// cannot stall, so it must take every result on the cycle it appears. A push, a
// refused push or pop, a reverse of fewer than two entries and the unused kind
// give their result in the cycle after start. A pop of a stored entry waits in
// S_POP for the registered RAM read data. A reverse walks S_RV_RDLO, S_RV_RDHI,
// S_RV_WRLO and S_RV_WRHI once per swapped pair: each pair costs two reads and
// two writes through the single read port and single write port of the RAM.
// busy is high while a pop or a reverse is under way; a new request may be given
// in the same cycle that o_done shows the previous result. Entries live in one
// RAM of STACK_DEPTH words that needs no clearing: only entries below the fill
// level are ever read, and each of them was pushed first. entry_count carries
// the low five bits of the fill level; is_empty and is_full are always exact.
module bounded_stack_with_reverse_unit
    import bsr_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(STACK_DEPTH);

    // sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_POP     = 3'd1;   // RAM read data for the pop is valid
    localparam logic [2:0] S_RV_RDLO = 3'd2;   // read low entry of the pair
    localparam logic [2:0] S_RV_RDHI = 3'd3;   // read high entry, catch low word
    localparam logic [2:0] S_RV_WRLO = 3'd4;   // high word goes to low slot
    localparam logic [2:0] S_RV_WRHI = 3'd5;   // low word goes to high slot

    logic [2:0]    r_state, n_state;
    logic [FW-1:0] r_fill,  n_fill;
    logic [AW-1:0] r_lo,    n_lo;
    logic [AW-1:0] r_hi,    n_hi;
    logic [31:0]   r_tmp,   n_tmp;
    t_res          r_res,   n_res;
    logic          r_done,  n_done;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic w_accept;
    logic w_empty;
    logic w_full;

    // Result word built from the fill level as it stands after the request.
    function automatic t_res make_res(input logic [31:0] pop_w, input logic [1:0] st,
                                      input logic [FW-1:0] fill);
        t_res res;
        res.pop_value   = pop_w;
        res.status      = st;
        res.entry_count = 5'(fill);
        res.is_empty    = (fill == '0);
        res.is_full     = (fill == FILL_MAX);
        return res;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_empty  = (r_fill == '0);
    assign w_full   = (r_fill == FILL_MAX);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_tmp     = r_tmp;
        n_res     = r_res;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_lo;
        ram_wdata = ram_rdata;
        ram_raddr = r_lo;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        KIND_PUSH: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_res = make_res('0, STATUS_FULL, r_fill);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_fill);
                                ram_wdata = i_req.push_value;
                                n_fill    = r_fill + 1'b1;
                                n_res     = make_res('0, STATUS_OK, r_fill + 1'b1);
                            end
                        end
                        KIND_POP: begin
                            if (w_empty) begin
                                n_done = 1'b1;
                                n_res  = make_res(EMPTY_POP_WORD, STATUS_EMPTY, r_fill);
                            end else begin
                                ram_raddr = AW'(r_fill - 1'b1);
                                n_fill    = r_fill - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        KIND_REVERSE: begin
                            // zero or one entry: order is already its own reverse
                            if (r_fill < FW'(2)) begin
                                n_done = 1'b1;
                                n_res  = make_res('0, STATUS_OK, r_fill);
                            end else begin
                                n_lo    = '0;
                                n_hi    = AW'(r_fill - 1'b1);
                                n_state = S_RV_RDLO;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = make_res('0, STATUS_OK, r_fill);
                        end
                    endcase
                end
            end
            S_POP: begin
                n_done  = 1'b1;
                n_res   = make_res(ram_rdata, STATUS_OK, r_fill);
                n_state = S_IDLE;
            end
            S_RV_RDLO: begin
                ram_raddr = r_lo;
                n_state   = S_RV_RDHI;
            end
            S_RV_RDHI: begin
                ram_raddr = r_hi;
                n_tmp     = ram_rdata;
                n_state   = S_RV_WRLO;
            end
            S_RV_WRLO: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo;
                ram_wdata = ram_rdata;
                n_state   = S_RV_WRHI;
            end
            S_RV_WRHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = r_tmp;
                n_lo      = r_lo + 1'b1;
                n_hi      = r_hi - 1'b1;
                // walk inward until the pointers meet or cross
                if ((r_lo + 1'b1) < (r_hi - 1'b1)) begin
                    n_state = S_RV_RDLO;
                end else begin
                    n_done  = 1'b1;
                    n_res   = make_res('0, STATUS_OK, r_fill);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_tmp <= n_tmp;
        r_res <= n_res;
    end

    bsr_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: design/bsr_checker.sv
// Port-level checks for the bounded stack with reverse, bound to the top level.
module bsr_checker
    import bsr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_done,
    input t_res o_res
);

    // a push never waits on the RAM
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.kind == KIND_PUSH) |=> o_done)
        else $error("push result not in next cycle");

    // results only come out once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.is_empty |-> (o_res.entry_count == 5'd0) && !o_res.is_full)
        else $error("empty flag disagrees with count or full flag");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_res.status == STATUS_EMPTY) |->
            (o_res.pop_value == EMPTY_POP_WORD) && o_res.is_empty)
        else $error("refused pop word wrong");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_res.status == STATUS_FULL) |-> o_res.is_full && (o_res.pop_value == '0))
        else $error("refused push on non-full stack");

endmodule

bind bounded_stack_with_reverse_unit bsr_checker u_bsr_checker (.*);
